[src/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Heap geometry, descriptor layout, command and status codes.
// ----------------------------------------------------------------------------
package ffba_pkg;

   localparam int HEAP_BYTES   = 1024 * 1024;
   localparam int HEADER_BYTES = 24;
   localparam int MAX_BLOCKS   = 256;

   localparam int ADDR_W = 20;                      // heap byte offsets
   localparam int REQ_W  = 21;                      // request size
   localparam int IDX_W  = $clog2(MAX_BLOCKS);      // descriptor index
   localparam int LINK_W = IDX_W + 1;               // index or null

   localparam logic [LINK_W-1:0] NULL_LINK  = LINK_W'(MAX_BLOCKS);
   localparam logic [ADDR_W-1:0] HDR        = ADDR_W'(HEADER_BYTES);
   localparam logic [ADDR_W-1:0] HEAD_SIZE  = ADDR_W'(HEAP_BYTES - HEADER_BYTES);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NO_SPACE    = 2'd1;
   localparam logic [1:0] ST_BAD_ADDRESS = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] size;
      logic              is_free;
      logic [LINK_W-1:0] link;
   } desc_type;

   localparam int DESC_W = $bits(desc_type);

endpackage

[src/ffba_ram.sv]
// ----------------------------------------------------------------------------
// ffba_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ffba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/first_fit_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core: first-fit heap allocator with coalescing
//
// Usage:
//   Request words come in on req_*: tuser carries the command (allocate or
//   free), tdata the request size and the payload address. Each request
//   gives exactly one response word on rsp_*: the payload address of the
//   allocated block, zero otherwise, and a status (ok, no_space, bad_address).
//   Block descriptors sit in a 256-entry RAM kept as an address-ordered
//   linked list; one sequencer walks it, one descriptor read per cycle.
//   After a request is accepted, allocate walks the list to the first free
//   block that fits; a split then takes a spare index (popped from the
//   recycle stack when it holds one) and writes the free remainder and the
//   allocated descriptor. Free walks the list to the block, absorbs its
//   successor when that is free, and writes the block back or merges it into a
//   free predecessor. req_tready rises when the response is loaded. The
//   worst case is set by the list walk through the single RAM read port. The
//   block takes one request at a time.
//   Reset: one cycle after reset the head descriptor is written (one free
//   block covering the heap less one header); req_tready rises after that.
//   A stalled rsp_tready holds the response in its output register; the
//   next request may still be accepted and walked meanwhile, and its
//   result waits until the output register drains.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core
   import ffba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,    // [0] command
   input  logic [47:0] req_tdata,    // [20:0] request_size, [40:21] payload_address
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata     // [19:0] result_address, [21:20] status
);

   // sequencer states
   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_CHK    = 3'd2;
   localparam logic [2:0] S_SPARE  = 3'd3;
   localparam logic [2:0] S_SPLIT  = 3'd4;
   localparam logic [2:0] S_SPLIT2 = 3'd5;
   localparam logic [2:0] S_NXCHK  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic              prv_ff, prv_in;          // in the merge-with-previous step
   logic              cmd_ff, cmd_in;
   logic [REQ_W-1:0]  size_ff, size_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   desc_type          cur_d_ff, cur_d_in;
   logic [IDX_W-1:0]  prev_ff, prev_in;
   logic              prev_ok_ff, prev_ok_in;
   desc_type          prev_d_ff, prev_d_in;
   logic [IDX_W-1:0]  spare_ff, spare_in;
   logic [IDX_W-1:0]  sp_ff, sp_in;            // recycled-index stack depth
   logic [LINK_W-1:0] fresh_ff, fresh_in;      // next never-used index
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [1:0]        res_st_ff, res_st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [23:0]       rsp_data_ff, rsp_data_in;

   // descriptor RAM ports
   logic                  d_we;
   logic [IDX_W-1:0]      d_waddr, d_raddr;
   desc_type              d_wdata, d;
   logic [DESC_W-1:0]     d_rdata;

   // index stack RAM ports
   logic                  s_we;
   logic [IDX_W-1:0]      s_waddr, s_raddr, s_rdata;
   logic [IDX_W-1:0]      s_wdata_w;

   ffba_ram #(.WIDTH(DESC_W), .DEPTH(MAX_BLOCKS)) u_desc (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (d_wdata),
      .rd_addr (d_raddr),
      .rd_data (d_rdata)
   );

   ffba_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BLOCKS)) u_stack (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata_w),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   assign d = desc_type'(d_rdata);

   // datapath terms used by the sequencer
   logic              fits, can_split, has_spare, hit;
   logic [REQ_W+1:0]  need;
   logic [ADDR_W-1:0] merged_next, merged_prev;

   assign fits      = ({1'b0, d.size} >= size_ff);
   assign need      = {2'b0, size_ff} + (REQ_W+2)'(HEADER_BYTES);
   assign can_split = ({3'b0, d.size} > need) && has_spare;
   assign has_spare = (sp_ff != '0) || (fresh_ff != NULL_LINK);
   assign hit       = (({1'b0, d.offset} + (ADDR_W+1)'(HEADER_BYTES)) == {1'b0, addr_ff});
   assign merged_next = cur_d_ff.size + HDR + d.size;
   assign merged_prev = prev_d_ff.size + HDR + cur_d_ff.size;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in    = state_ff;
      prv_in      = 1'b0;
      cmd_in      = cmd_ff;
      size_in     = size_ff;
      addr_in     = addr_ff;
      cur_in      = cur_ff;
      cur_d_in    = cur_d_ff;
      prev_in     = prev_ff;
      prev_ok_in  = prev_ok_ff;
      prev_d_in   = prev_d_ff;
      spare_in    = spare_ff;
      sp_in       = sp_ff;
      fresh_in    = fresh_ff;
      res_addr_in = res_addr_ff;
      res_st_in   = res_st_ff;
      d_we        = 1'b0;
      d_waddr     = cur_ff;
      d_wdata     = cur_d_ff;
      d_raddr     = '0;
      s_we        = 1'b0;
      s_waddr     = sp_ff;
      s_wdata_w   = cur_ff;
      s_raddr     = sp_ff - IDX_W'(1);

      // output register: drain, then refill from a finished result
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_INIT: begin
            // write the head descriptor: one free block over the whole heap
            d_we     = 1'b1;
            d_waddr  = '0;
            d_wdata  = '{offset: '0, size: HEAD_SIZE, is_free: 1'b1, link: NULL_LINK};
            sp_in    = '0;
            fresh_in = LINK_W'(1);
            state_in = S_IDLE;
         end
         S_IDLE: begin
            d_raddr = '0;
            if (req_tvalid) begin
               cmd_in     = req_tuser;
               size_in    = req_tdata[20:0];
               addr_in    = req_tdata[40:21];
               cur_in     = '0;
               prev_ok_in = 1'b0;
               state_in   = S_CHK;
            end
         end
         S_CHK: begin
            // descriptor of cur_ff is on d; prefetch its successor
            d_raddr  = d.link[IDX_W-1:0];
            cur_d_in = d;
            if (cmd_ff == CMD_ALLOC) begin
               if (d.is_free && fits) begin
                  res_addr_in = d.offset + HDR;
                  res_st_in   = ST_OK;
                  if (can_split) begin
                     if (sp_ff != '0) begin
                        sp_in    = sp_ff - IDX_W'(1);
                        state_in = S_SPARE;
                     end else begin
                        spare_in = fresh_ff[IDX_W-1:0];
                        fresh_in = fresh_ff + LINK_W'(1);
                        state_in = S_SPLIT;
                     end
                  end else begin
                     d_we     = 1'b1;
                     d_waddr  = cur_ff;
                     d_wdata  = d;
                     d_wdata.is_free = 1'b0;
                     state_in = S_DONE;
                  end
               end else if (d.link == NULL_LINK) begin
                  res_addr_in = '0;
                  res_st_in   = ST_NO_SPACE;
                  state_in    = S_DONE;
               end else begin
                  cur_in = d.link[IDX_W-1:0];
               end
            end else begin
               if (hit) begin
                  cur_d_in.is_free = 1'b1;
                  res_addr_in      = '0;
                  res_st_in        = ST_OK;
                  if (d.link != NULL_LINK) begin
                     state_in = S_NXCHK;
                  end else begin
                     prv_in   = 1'b1;
                     state_in = S_DONE;
                  end
               end else if (d.link == NULL_LINK) begin
                  res_addr_in = '0;
                  res_st_in   = ST_BAD_ADDRESS;
                  state_in    = S_DONE;
               end else begin
                  prev_in    = cur_ff;
                  prev_ok_in = 1'b1;
                  prev_d_in  = d;
                  cur_in     = d.link[IDX_W-1:0];
               end
            end
         end
         S_SPARE: begin
            // popped index arrives from the stack RAM
            spare_in = s_rdata;
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            // new free remainder after the allocated payload
            d_we    = 1'b1;
            d_waddr = spare_ff;
            d_wdata = '{offset: cur_d_ff.offset + HDR + size_ff[ADDR_W-1:0],
                        size: cur_d_ff.size - size_ff[ADDR_W-1:0] - HDR,
                        is_free: 1'b1, link: cur_d_ff.link};
            state_in = S_SPLIT2;
         end
         S_SPLIT2: begin
            d_we    = 1'b1;
            d_waddr = cur_ff;
            d_wdata = '{offset: cur_d_ff.offset, size: size_ff[ADDR_W-1:0],
                        is_free: 1'b0, link: {1'b0, spare_ff}};
            state_in = S_DONE;
         end
         S_NXCHK: begin
            // successor descriptor on d: absorb it when free
            if (d.is_free) begin
               cur_d_in.size = merged_next;
               cur_d_in.link = d.link;
               s_we      = 1'b1;
               s_wdata_w = cur_d_ff.link[IDX_W-1:0];
               sp_in     = sp_ff + IDX_W'(1);
            end
            prv_in   = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (prv_ff) begin
               // merge into a free predecessor, or write the freed block back
               if (prev_ok_ff && prev_d_ff.is_free) begin
                  d_we    = 1'b1;
                  d_waddr = prev_ff;
                  d_wdata = prev_d_ff;
                  d_wdata.size = merged_prev;
                  d_wdata.link = cur_d_ff.link;
                  s_we      = 1'b1;
                  s_wdata_w = cur_ff;
                  sp_in     = sp_ff + IDX_W'(1);
               end else begin
                  d_we    = 1'b1;
                  d_waddr = cur_ff;
                  d_wdata = cur_d_ff;
               end
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b0, res_st_ff, res_addr_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         prv_ff       <= 1'b0;
         sp_ff        <= '0;
         fresh_ff     <= LINK_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prv_ff       <= prv_in;
         sp_ff        <= sp_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      size_ff     <= size_in;
      addr_ff     <= addr_in;
      cur_ff      <= cur_in;
      cur_d_ff    <= cur_d_in;
      prev_ff     <= prev_in;
      prev_ok_ff  <= prev_ok_in;
      prev_d_ff   <= prev_d_in;
      spare_ff    <= spare_in;
      res_addr_ff <= res_addr_in;
      res_st_ff   <= res_st_in;
      rsp_data_ff <= rsp_data_in;
   end

   // fresh indexes never run past the descriptor count
   a_fresh_range: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= NULL_LINK)
      else $error("fresh index out of range");

   // a non-ok response carries a zero address
   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[21:20] != ST_OK) |-> (rsp_data_ff[19:0] == '0))
      else $error("nonzero address with error status");

   // an accepted request starts the list walk at the head
   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_CHK && cur_ff == '0))
      else $error("walk did not start at head");

   // the response register only loads on leaving the done state
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> ($past(state_ff) == S_DONE))
      else $error("response loaded outside done state");

endmodule

[sim/first_fit_block_allocator_core_test.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core_test: self-checking bench for the allocator
// Drives allocate and free words, predicts every response with a descriptor
// list kept in the bench, and compares address and status field by field.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core_test
   import ffba_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_CYCLES = 20000;
   localparam int STALL_CYCLES    = 400;

   typedef struct packed {
      logic              cmd;
      logic [REQ_W-1:0]  size;
      logic [ADDR_W-1:0] addr;
   } heap_request_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [1:0]        status;
   } heap_response_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic        req_tuser;    // [0] command
   logic [47:0] req_tdata;    // [20:0] request_size, [40:21] payload_address
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // [19:0] result_address, [21:20] status

   first_fit_block_allocator_core DUT (.*);

   // Bench copy of the descriptor list.
   logic [ADDR_W-1:0] heap_offset [MAX_BLOCKS];
   logic [ADDR_W-1:0] heap_len    [MAX_BLOCKS];
   logic              heap_free   [MAX_BLOCKS];
   int                heap_link   [MAX_BLOCKS];
   logic              heap_used   [MAX_BLOCKS];

   heap_request_type  pending_requests[$];
   heap_response_type expected_responses[$];
   logic [ADDR_W-1:0] live_payloads[$];   // addresses handed out and not yet freed

   int  error_count = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  idle_cycles;
   int  send_gap;
   int  recv_gap;
   int  hold_off;           // long receiver stall, counted in its own process
   int  stall_requests = 0; // raised by the stimulus to start a long stall
   int  stall_served;
   bit  sender_pause = 0;   // hold the sender until all responses have drained
   int  alloc_ok = 0, alloc_full = 0, free_ok = 0, free_bad = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0h expected %0h (word %0d)", what, got, want,
               words_checked);
      error_count++;
   endtask

   function automatic int next_block(input int i);
      int n;
      n = heap_link[i];
      if (n >= MAX_BLOCKS || !heap_used[n]) return MAX_BLOCKS;
      return n;
   endfunction

   function automatic void heap_clear();
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         heap_offset[i] = '0;
         heap_len[i]    = '0;
         heap_free[i]   = 1'b0;
         heap_link[i]   = MAX_BLOCKS;
         heap_used[i]   = 1'b0;
      end
      heap_len[0]  = HEAD_SIZE;
      heap_free[0] = 1'b1;
      heap_used[0] = 1'b1;
   endfunction

   // Merge the successor of block a into a.
   function automatic void merge_next(input int a);
      int b;
      b = next_block(a);
      if (b == MAX_BLOCKS) return;
      heap_len[a]  = heap_len[a] + HDR + heap_len[b];
      heap_link[a] = heap_link[b];
      heap_used[b] = 1'b0;
      heap_free[b] = 1'b0;
   endfunction

   // Apply one request to the bench heap and return the response it gives.
   function automatic heap_response_type predict_heap(input heap_request_type rq);
      heap_response_type rs;
      int cur, prev, spare, nx;
      bit found;
      logic [31:0] req, sz;
      cur = 0;
      prev = MAX_BLOCKS;
      found = 0;
      rs = '0;
      req = 32'(rq.size);
      if (rq.cmd == CMD_ALLOC) begin
         rs.status = ST_NO_SPACE;
         for (int steps = 0; steps < MAX_BLOCKS && cur != MAX_BLOCKS; steps++) begin
            sz = 32'(heap_len[cur]);
            if (heap_free[cur] && sz >= req) begin
               spare = MAX_BLOCKS;
               for (int i = MAX_BLOCKS - 1; i >= 0; i--) if (!heap_used[i]) spare = i;
               if (sz > req + HEADER_BYTES && spare != MAX_BLOCKS) begin
                  heap_offset[spare] = ADDR_W'(32'(heap_offset[cur]) + HEADER_BYTES + req);
                  heap_len[spare]    = ADDR_W'(sz - req - HEADER_BYTES);
                  heap_free[spare]   = 1'b1;
                  heap_link[spare]   = heap_link[cur];
                  heap_used[spare]   = 1'b1;
                  heap_len[cur]      = ADDR_W'(req);
                  heap_link[cur]     = spare;
               end
               heap_free[cur] = 1'b0;
               rs.addr   = heap_offset[cur] + HDR;
               rs.status = ST_OK;
               break;
            end
            cur = next_block(cur);
         end
      end else begin
         for (int steps = 0; steps < MAX_BLOCKS && cur != MAX_BLOCKS; steps++) begin
            if (32'(heap_offset[cur]) + HEADER_BYTES == 32'(rq.addr)) begin
               found = 1;
               break;
            end
            prev = cur;
            cur = next_block(cur);
         end
         if (!found) begin
            rs.status = ST_BAD_ADDRESS;
         end else begin
            heap_free[cur] = 1'b1;
            nx = next_block(cur);
            if (nx != MAX_BLOCKS && heap_free[nx]) merge_next(cur);
            if (prev != MAX_BLOCKS && heap_free[prev]) merge_next(prev);
         end
      end
      return rs;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   function automatic void push_alloc(input logic [REQ_W-1:0] size);
      heap_request_type rq;
      rq.cmd  = CMD_ALLOC;
      rq.size = size;
      rq.addr = ADDR_W'($urandom);
      pending_requests.push_back(rq);
   endfunction

   function automatic void push_free(input logic [ADDR_W-1:0] addr);
      heap_request_type rq;
      rq.cmd  = CMD_FREE;
      rq.size = REQ_W'($urandom);
      rq.addr = addr;
      pending_requests.push_back(rq);
   endfunction

   // Driver: offer the head of the pending queue, advance on handshake.
   always @(posedge clock) begin
      heap_request_type rq;
      heap_response_type rs;
      int gap;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tuser  <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
         heap_clear();
      end else begin
         if (req_tvalid && req_tready) begin
            rq = pending_requests.pop_front();
            rs = predict_heap(rq);
            expected_responses.push_back(rs);
            words_sent++;
            // Track live payloads so later frees hit real blocks.
            if (rq.cmd == CMD_ALLOC && rs.status == ST_OK) begin
               live_payloads.push_back(rs.addr);
               alloc_ok++;
            end else if (rq.cmd == CMD_ALLOC) begin
               alloc_full++;
            end else if (rs.status == ST_OK) begin
               free_ok++;
            end else begin
               free_bad++;
            end
         end
         if (req_tvalid && !req_tready) begin
            // hold the word until it is taken
         end else if (send_gap > 0 || sender_pause || pending_requests.size() == 0) begin
            req_tvalid <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
         end else begin
            if (req_tvalid && req_tready) gap = pick_gap();
            else gap = 0;
            if (gap == 0) begin
               rq = pending_requests[0];
               req_tvalid <= 1'b1;
               req_tuser  <= rq.cmd;
               req_tdata  <= {7'd0, rq.addr, rq.size};
            end else begin
               req_tvalid <= 1'b0;
               send_gap   <= gap - 1;
            end
         end
      end
   end

   // Long receiver stall: count it down here, start one per stimulus request.
   always @(posedge clock) begin
      if (reset) begin
         hold_off     <= 0;
         stall_served <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
      end else if (stall_served != stall_requests) begin
         hold_off     <= STALL_CYCLES;
         stall_served <= stall_served + 1;
      end
   end

   // Monitor: check each response word, pace rsp_tready, count idle cycles.
   always @(posedge clock) begin
      heap_response_type got, want;
      if (reset) begin
         rsp_tready  <= 1'b0;
         recv_gap    <= 0;
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = heap_response_type'({rsp_tdata[19:0], rsp_tdata[21:20]});
            words_checked++;
            if (expected_responses.size() == 0) begin
               report_mismatch("unexpected word", int'(rsp_tdata), 0);
            end else begin
               want = expected_responses.pop_front();
               if (got.addr !== want.addr)
                  report_mismatch("result_address", int'(got.addr), int'(want.addr));
               if (got.status !== want.status)
                  report_mismatch("status", int'(got.status), int'(want.status));
            end
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            rsp_tready <= 1'b0;
            recv_gap   <= recv_gap - 1;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready) recv_gap <= pick_gap();
         end
      end
   end

   // Watchdog: no handshake for too long means the block hung.
   always @(posedge clock) begin
      if (!reset && idle_cycles >= WATCHDOG_CYCLES) begin
         $display("watchdog: no word moved for %0d cycles", idle_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_requests.size() != 0 || expected_responses.size() != 0)
         @(posedge clock);
   endtask

   task automatic wait_room();
      while (pending_requests.size() >= 4) @(posedge clock);
   endtask

   // Random phase: mostly well-formed alloc/free traffic, some noise.
   task automatic random_traffic(input int count);
      int pick, k;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // small sizes mostly, rarely huge so the heap can run out
            if ($urandom_range(0, 19) == 0) push_alloc(REQ_W'($urandom_range(0, 1 << 20)));
            else if ($urandom_range(0, 9) == 0) push_alloc(REQ_W'($urandom));
            else push_alloc(REQ_W'($urandom_range(0, 4096)));
         end else if (pick < 85 && live_payloads.size() > 0) begin
            k = $urandom_range(0, live_payloads.size() - 1);
            push_free(live_payloads[k]);
            live_payloads.delete(k);
         end else if (pick < 93) begin
            push_free(ADDR_W'($urandom));
         end else begin
            push_free(HDR + ADDR_W'($urandom_range(0, 64)));
         end
         // keep the live list in step with what the driver learns
         wait_room();
      end
   endtask

   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, zero size, exact fit, unknown address, double free.
      push_free('0);                          // address zero is never a payload
      push_alloc('0);                         // zero-byte block
      push_free(HDR);                         // free it by its payload
      push_free(HDR);                         // freeing a free block is ok
      push_alloc(REQ_W'(HEAP_BYTES));         // larger than the heap
      push_alloc(REQ_W'(HEAP_BYTES - HEADER_BYTES)); // whole heap, exact fit
      push_alloc(REQ_W'(1));                  // nothing left
      push_free(HDR);
      push_alloc(REQ_W'(HEAP_BYTES - 2 * HEADER_BYTES)); // no room to split
      push_free(HDR);
      push_alloc(REQ_W'(HEAP_BYTES - 2 * HEADER_BYTES - 1)); // split leaves one byte
      push_free(ADDR_W'('1));                 // all-ones address
      push_alloc(REQ_W'('1));                 // all-ones size
      push_free(HDR);
      push_free(ADDR_W'(HEAP_BYTES - HEADER_BYTES));
      for (int i = 0; i < 6; i++) push_alloc(REQ_W'(100 * i));
      wait_drained();
      // return the directed blocks to the free pool by freeing all live ones
      while (live_payloads.size() > 0) push_free(live_payloads.pop_front());
      wait_drained();

      // Exhaust descriptors so whole-block takes happen, then release them.
      for (int i = 0; i < MAX_BLOCKS + 4; i++) push_alloc(REQ_W'($urandom_range(0, 40)));
      // long receiver stall while the sender keeps offering: the block stalls
      stall_requests = stall_requests + 1;
      wait_drained();
      while (live_payloads.size() > 0) begin
         int k;
         k = $urandom_range(0, live_payloads.size() - 1);
         push_free(live_payloads[k]);
         live_payloads.delete(k);
         wait_room();
      end
      wait_drained();

      random_traffic(600);
      // sender waits for every response before going on
      sender_pause = 1;
      while (expected_responses.size() != 0 || req_tvalid) @(posedge clock);
      sender_pause = 0;
      random_traffic(600);
      wait_drained();
      repeat (300) @(posedge clock);

      $display("covered directed edge cases, descriptor exhaustion under a long stall,");
      $display("and random traffic: %0d words sent, %0d checked (allocs ok %0d, full %0d, frees ok %0d, bad %0d)",
               words_sent, words_checked, alloc_ok, alloc_full, free_ok, free_bad);
      if (error_count == 0 && expected_responses.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
